// File: rtl/core/cl2d_pkg.sv
`default_nettype none
package cl2d_pkg;
    localparam int MAX_IN_CH_D   = 16;
    localparam int MAX_OUT_CH_D  = 16;
    localparam int MAX_KERNEL_D  = 5;
    localparam int MAX_MAP_DIM_D = 32;
    localparam int FRAC_BITS_D   = 8;

    localparam int NUM_REGS = 8;

    localparam logic [1:0] OP_WEIGHT  = 2'd0;
    localparam logic [1:0] OP_BIAS    = 2'd1;
    localparam logic [1:0] OP_SAMPLE  = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    localparam logic [2:0] REG_PAD    = 3'd0;
    localparam logic [2:0] REG_STRIDE = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_NIC    = 3'd4;
    localparam logic [2:0] REG_NOC    = 3'd5;
    localparam logic [2:0] REG_KR     = 3'd6;
    localparam logic [2:0] REG_KC     = 3'd7;

    typedef struct packed {
        logic [3:0] oc;
        logic [4:0] r;
        logic [4:0] c;
        logic       bad;
    } job_t;

    typedef struct packed {
        logic [1:0] pad;
        logic [2:0] st;
        logic [5:0] h;
        logic [5:0] w;
        logic [4:0] nic;
        logic [4:0] kr;
        logic [4:0] kc;
    } geom_t;
endpackage
`default_nettype wire

// File: rtl/core/cl2d_front.sv
`default_nettype none
module cl2d_front #(
    parameter int MAX_IN_CH   = cl2d_pkg::MAX_IN_CH_D,
    parameter int MAX_OUT_CH  = cl2d_pkg::MAX_OUT_CH_D,
    parameter int MAX_MAP_DIM = cl2d_pkg::MAX_MAP_DIM_D,
    parameter int MAX_KERNEL  = cl2d_pkg::MAX_KERNEL_D
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [5:0]           cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           operation,
    input  wire logic [3:0]           out_channel,
    input  wire logic [4:0]           row_index,
    input  wire logic [4:0]           col_index,
    output logic                      job_push,
    output cl2d_pkg::job_t            job,
    input  wire logic                 job_full,
    input  wire logic                 job_pending,
    input  wire logic                 back_busy,
    output cl2d_pkg::geom_t           geom
);
    localparam int HMAX  = (MAX_MAP_DIM < 32) ? MAX_MAP_DIM : 32;
    localparam int CMAX  = (MAX_IN_CH < 16) ? MAX_IN_CH : 16;
    localparam int OMAX  = (MAX_OUT_CH < 16) ? MAX_OUT_CH : 16;
    localparam int KMAX  = (MAX_KERNEL < 5) ? MAX_KERNEL : 5;

    logic [1:0] pad_reg;
    logic [2:0] st_reg, kr_reg, kc_reg;
    logic [5:0] h_reg, w_reg;
    logic [4:0] nic_reg, noc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg <= 2'd0; st_reg <= 3'd1; h_reg <= 6'd28; w_reg <= 6'd28;
            nic_reg <= 5'd1; noc_reg <= 5'd6; kr_reg <= 3'd5; kc_reg <= 3'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cl2d_pkg::REG_PAD:    pad_reg <= cfg_data[1:0];
                cl2d_pkg::REG_STRIDE: st_reg  <= cfg_data[2:0];
                cl2d_pkg::REG_HEIGHT: h_reg   <= cfg_data;
                cl2d_pkg::REG_WIDTH:  w_reg   <= cfg_data;
                cl2d_pkg::REG_NIC:    nic_reg <= cfg_data[4:0];
                cl2d_pkg::REG_NOC:    noc_reg <= cfg_data[4:0];
                cl2d_pkg::REG_KR:     kr_reg  <= cfg_data[2:0];
                cl2d_pkg::REG_KC:     kc_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    function automatic logic [6:0] clampv(input logic [6:0] v, input int hi);
        if (v == 7'd0) return 7'd1;
        if (int'(v) > hi) return 7'(hi);
        return v;
    endfunction

    logic [6:0] pad_c, st_c, h_c, w_c, nic_c, noc_c, kr_c, kc_c;
    always_comb
    begin
        pad_c = (pad_reg == 2'd3) ? 7'd2 : {5'd0, pad_reg};
        st_c  = (st_reg == 3'd0) ? 7'd1 : ((st_reg > 3'd4) ? 7'd4 : {4'd0, st_reg});
        h_c   = clampv({1'b0, h_reg}, HMAX);
        w_c   = clampv({1'b0, w_reg}, HMAX);
        nic_c = clampv({2'd0, nic_reg}, CMAX);
        noc_c = clampv({2'd0, noc_reg}, OMAX);
        kr_c  = clampv({4'd0, kr_reg}, KMAX);
        kc_c  = clampv({4'd0, kc_reg}, KMAX);
    end

    assign geom.pad = pad_c[1:0];
    assign geom.st  = st_c[2:0];
    assign geom.h   = h_c[5:0];
    assign geom.w   = w_c[5:0];
    assign geom.nic = nic_c[4:0];
    assign geom.kr  = kr_c[4:0];
    assign geom.kc  = kc_c[4:0];

    // last valid output index: out < yrows  <=>  out*st + k <= dim + 2*pad
    logic [7:0] pr_span, pc_span, rlast, clast;
    logic       r_bad, c_bad;
    always_comb
    begin
        pr_span = 8'(h_c) + 8'(pad_c) + 8'(pad_c);
        pc_span = 8'(w_c) + 8'(pad_c) + 8'(pad_c);
        rlast   = 8'(row_index) * 8'(st_c[2:0]);
        clast   = 8'(col_index) * 8'(st_c[2:0]);
        r_bad   = (10'(rlast) + 10'(kr_c)) > 10'(pr_span);
        c_bad   = (10'(clast) + 10'(kc_c)) > 10'(pc_span);
    end

    // hold loads until every earlier compute has read the stores
    assign full     = job_full || ((operation != cl2d_pkg::OP_COMPUTE)
                                   && (job_pending || back_busy));
    assign job_push = push && !full && (operation == cl2d_pkg::OP_COMPUTE);
    assign job.oc   = out_channel;
    assign job.r    = row_index;
    assign job.c    = col_index;
    assign job.bad  = ({1'b0, out_channel} >= noc_c[4:0]) || r_bad || c_bad;
endmodule
`default_nettype wire

// File: rtl/core/cl2d_queue.sv
`default_nettype none
module cl2d_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  cl2d_pkg::job_t      wdata,
    output logic                q_full,
    input  wire logic           rd,
    output logic                q_empty,
    output cl2d_pkg::job_t      rdata
);
    cl2d_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr && !q_full) mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr && !q_full) wp_reg <= !wp_reg;
            if (rd && !q_empty) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr && !q_full) - 2'(rd && !q_empty);
        end
    end

    assign q_full  = cnt_reg == 2'd2;
    assign q_empty = cnt_reg == 2'd0;
    assign rdata   = mem_reg[rp_reg];
endmodule
`default_nettype wire

// File: rtl/core/cl2d_back.sv
`default_nettype none
module cl2d_back #(
    parameter int MAX_IN_CH   = cl2d_pkg::MAX_IN_CH_D,
    parameter int MAX_OUT_CH  = cl2d_pkg::MAX_OUT_CH_D,
    parameter int MAX_KERNEL  = cl2d_pkg::MAX_KERNEL_D,
    parameter int MAX_MAP_DIM = cl2d_pkg::MAX_MAP_DIM_D,
    parameter int FRAC_BITS   = cl2d_pkg::FRAC_BITS_D
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            ld_en,
    input  wire logic [1:0]      operation,
    input  wire logic [3:0]      out_channel,
    input  wire logic [3:0]      in_channel,
    input  wire logic [4:0]      row_index,
    input  wire logic [4:0]      col_index,
    input  wire logic signed [15:0] data_value,
    input  cl2d_pkg::geom_t      geom,
    input  wire logic            q_empty,
    input  cl2d_pkg::job_t       q_job,
    output logic                 q_rd,
    output logic                 busy,
    output logic                 empty,
    input  wire logic            pop,
    output logic [3:0]           res_channel,
    output logic [4:0]           res_row,
    output logic [4:0]           res_col,
    output logic signed [31:0]   res_value,
    output logic                 res_status
);
    localparam int W_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
    localparam int X_DEPTH = MAX_IN_CH * MAX_MAP_DIM * MAX_MAP_DIM;
    localparam int WAW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int XAW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
    localparam int BAW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int ACCW = 48;

    logic signed [15:0] wmem [W_DEPTH];
    logic signed [15:0] xmem [X_DEPTH];
    logic signed [15:0] bmem [MAX_OUT_CH];

    logic [WAW-1:0] wa_ld, wa_rd;
    logic [XAW-1:0] xa_ld, xa_rd;
    logic           w_ok, x_ok, b_ok;

    always_comb
    begin
        w_ok  = (int'(out_channel) < MAX_OUT_CH) && (int'(in_channel) < MAX_IN_CH)
             && (int'(row_index) < MAX_KERNEL) && (int'(col_index) < MAX_KERNEL);
        x_ok  = (int'(in_channel) < MAX_IN_CH) && (int'(row_index) < MAX_MAP_DIM)
             && (int'(col_index) < MAX_MAP_DIM);
        b_ok  = int'(out_channel) < MAX_OUT_CH;
        wa_ld = WAW'(((int'(out_channel) * MAX_IN_CH + int'(in_channel)) * MAX_KERNEL
              + int'(row_index)) * MAX_KERNEL + int'(col_index));
        xa_ld = XAW'((int'(in_channel) * MAX_MAP_DIM + int'(row_index)) * MAX_MAP_DIM
              + int'(col_index));
    end

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_RUN = 5'b00010, S_DRAIN = 5'b00100,
        S_BIAS = 5'b01000, S_OUT = 5'b10000
    } st_t;

    st_t          state_reg, state_next;
    cl2d_pkg::job_t job_reg;
    logic [4:0]   k_reg, i_reg, j_reg;
    logic signed [7:0] pr_reg, pc_reg;
    logic         rv_reg, mv_reg;
    logic signed [15:0] wq_reg, xq_reg, bq_reg;
    logic signed [31:0] prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic         full_reg;
    logic [1:0]   drain_reg;

    logic tap_ok, last_j, last_i, last_k;
    always_comb
    begin
        tap_ok = (pr_reg >= 0) && (pr_reg < $signed({2'b0, geom.h}))
              && (pc_reg >= 0) && (pc_reg < $signed({2'b0, geom.w}));
        last_j = (j_reg + 5'd1) == geom.kc;
        last_i = (i_reg + 5'd1) == geom.kr;
        last_k = (k_reg + 5'd1) == geom.nic;
        wa_rd  = WAW'(((int'(job_reg.oc) * MAX_IN_CH + int'(k_reg)) * MAX_KERNEL
               + int'(i_reg)) * MAX_KERNEL + int'(j_reg));
        xa_rd  = XAW'((int'(k_reg) * MAX_MAP_DIM + int'(pr_reg[4:0])) * MAX_MAP_DIM
               + int'(pc_reg[4:0]));
    end

    always_ff @(posedge clk)
    begin
        if (ld_en && operation == cl2d_pkg::OP_WEIGHT && w_ok) wmem[wa_ld] <= data_value;
        if (state_reg == S_RUN) wq_reg <= wmem[wa_rd];
    end
    always_ff @(posedge clk)
    begin
        if (ld_en && operation == cl2d_pkg::OP_SAMPLE && x_ok) xmem[xa_ld] <= data_value;
        if (state_reg == S_RUN) xq_reg <= xmem[xa_rd];
    end
    always_ff @(posedge clk)
    begin
        if (ld_en && operation == cl2d_pkg::OP_BIAS && b_ok)
            bmem[BAW'(out_channel)] <= data_value;
        bq_reg <= bmem[BAW'(job_reg.oc)];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (!q_empty && !full_reg)
                         state_next = q_job.bad ? S_OUT : S_RUN;
            S_RUN:   if (last_j && last_i && last_k) state_next = S_DRAIN;
            S_DRAIN: if (drain_reg == 2'd2) state_next = S_BIAS;
            S_BIAS:  state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end
    assign q_rd = (state_reg == S_IDLE) && !q_empty && !full_reg;
    assign busy = state_reg != S_IDLE;

    logic signed [ACCW-1:0] tot, fl;
    always_comb
    begin
        tot = acc_reg + (ACCW'(bq_reg) <<< FRAC_BITS);
        fl  = tot >>> FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; full_reg <= 1'b0; rv_reg <= 1'b0; mv_reg <= 1'b0;
            drain_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && full_reg) full_reg <= 1'b0;
            if (state_reg == S_OUT) full_reg <= 1'b1;
            rv_reg <= (state_reg == S_RUN) && tap_ok;
            mv_reg <= rv_reg;
            drain_reg <= (state_reg == S_DRAIN) ? drain_reg + 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            job_reg <= q_job;
            k_reg <= 5'd0; i_reg <= 5'd0; j_reg <= 5'd0;
            pr_reg <= $signed(8'(q_job.r) * 8'(geom.st)) - $signed({6'd0, geom.pad});
            pc_reg <= $signed(8'(q_job.c) * 8'(geom.st)) - $signed({6'd0, geom.pad});
            acc_reg <= '0;
        end
        else
        begin
            if (state_reg == S_RUN)
            begin
                if (!last_j)
                begin
                    j_reg <= j_reg + 5'd1; pc_reg <= pc_reg + 8'sd1;
                end
                else
                begin
                    j_reg <= 5'd0;
                    pc_reg <= $signed(8'(job_reg.c) * 8'(geom.st)) - $signed({6'd0, geom.pad});
                    if (!last_i)
                    begin
                        i_reg <= i_reg + 5'd1; pr_reg <= pr_reg + 8'sd1;
                    end
                    else
                    begin
                        i_reg <= 5'd0;
                        pr_reg <= $signed(8'(job_reg.r) * 8'(geom.st))
                                - $signed({6'd0, geom.pad});
                        k_reg <= k_reg + 5'd1;
                    end
                end
            end
            if (rv_reg) prod_reg <= wq_reg * xq_reg;
            if (mv_reg) acc_reg <= acc_reg + ACCW'(prod_reg);
        end
        if (state_reg == S_OUT)
        begin
            res_channel <= job_reg.oc;
            res_row     <= job_reg.r;
            res_col     <= job_reg.c;
            res_status  <= job_reg.bad;
            if (job_reg.bad) res_value <= 32'sd0;
            else if (fl > ACCW'(32'sh7fffffff)) res_value <= 32'sh7fffffff;
            else if (fl < -ACCW'(64'sh80000000)) res_value <= 32'sh80000000;
            else res_value <= fl[31:0];
        end
    end

    assign empty = !full_reg;
endmodule
`default_nettype wire

// File: rtl/core/convolution_layer_2d_unit.sv
// Flow: a load is stored at its accepting edge; a compute result passes the job queue, then
// the tap loop, drain, bias and output states; an out-of-range compute skips to the output state.
// Compute words queue while the single multiply-accumulate loop works on an earlier one, and
// the next queued job starts only once the result word has been popped.
// Loads wait while a compute is queued or running; a 2-entry job queue parts front and back.
// Reset: asynchronous, active low; registers return to defaults, stores stay undefined.
`default_nettype none
module convolution_layer_2d_unit #(
    parameter int MAX_IN_CH   = cl2d_pkg::MAX_IN_CH_D,
    parameter int MAX_OUT_CH  = cl2d_pkg::MAX_OUT_CH_D,
    parameter int MAX_KERNEL  = cl2d_pkg::MAX_KERNEL_D,
    parameter int MAX_MAP_DIM = cl2d_pkg::MAX_MAP_DIM_D,
    parameter int FRAC_BITS   = cl2d_pkg::FRAC_BITS_D
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [5:0]         cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         operation,
    input  wire logic [3:0]         out_channel,
    input  wire logic [3:0]         in_channel,
    input  wire logic [4:0]         row_index,
    input  wire logic [4:0]         col_index,
    input  wire logic signed [15:0] data_value,
    output logic                    empty,
    input  wire logic               pop,
    output logic [3:0]              res_channel,
    output logic [4:0]              res_row,
    output logic [4:0]              res_col,
    output logic signed [31:0]      res_value,
    output logic                    res_status
);
    cl2d_pkg::job_t  job, q_job;
    cl2d_pkg::geom_t geom;
    logic job_push, q_full, q_empty, q_rd, back_busy;

    cl2d_front #(.MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH),
                 .MAX_MAP_DIM(MAX_MAP_DIM), .MAX_KERNEL(MAX_KERNEL)) u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .push, .full, .operation,
        .out_channel, .row_index, .col_index, .job_push, .job, .job_full(q_full),
        .job_pending(!q_empty), .back_busy, .geom
    );

    cl2d_queue u_queue (
        .clk, .rst_n, .wr(job_push), .wdata(job), .q_full, .rd(q_rd), .q_empty,
        .rdata(q_job)
    );

    cl2d_back #(.MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH), .MAX_KERNEL(MAX_KERNEL),
                .MAX_MAP_DIM(MAX_MAP_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n, .ld_en(push && !full), .operation, .out_channel, .in_channel,
        .row_index, .col_index, .data_value, .geom, .q_empty, .q_job, .q_rd,
        .busy(back_busy), .empty, .pop, .res_channel, .res_row, .res_col, .res_value,
        .res_status
    );
endmodule
`default_nettype wire

// File: rtl/core/cl2d_checker.sv
`default_nettype none
module cl2d_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [3:0]  res_channel,
    input wire logic [31:0] res_value,
    input wire logic        res_status
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(res_value) && $stable(res_channel)))
        else $error("result word changed while waiting");
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && res_status) |-> (res_value == 32'd0))
        else $error("error status with nonzero value");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> empty)
        else $error("results back to back");
endmodule

bind convolution_layer_2d_unit cl2d_checker u_chk (
    .clk, .rst_n, .empty, .pop, .res_channel, .res_value, .res_status
);
`default_nettype wire

// File: tb/convolution_layer_2d_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module convolution_layer_2d_unit_tb;
    localparam int KTAPS = cl2d_pkg::MAX_KERNEL_D * cl2d_pkg::MAX_KERNEL_D;
    localparam int W_SIZE = cl2d_pkg::MAX_OUT_CH_D * cl2d_pkg::MAX_IN_CH_D * KTAPS;
    localparam int X_SIZE = cl2d_pkg::MAX_IN_CH_D * cl2d_pkg::MAX_MAP_DIM_D
                          * cl2d_pkg::MAX_MAP_DIM_D;
    localparam int SETTLE_CYCLES = 500;

    typedef struct {
        logic [3:0]         channel;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [31:0] value;
        logic               status;
    } conv_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [5:0]         cfg_data;
    logic               push;
    logic               full;
    logic [1:0]         operation;
    logic [3:0]         out_channel;
    logic [3:0]         in_channel;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [15:0] data_value;
    logic               empty;
    logic               pop;
    logic [3:0]         res_channel;
    logic [4:0]         res_row;
    logic [4:0]         res_col;
    logic signed [31:0] res_value;
    logic               res_status;

    conv_result_t conv_expected_q[$];
    logic [5:0]   layer_regs[cl2d_pkg::NUM_REGS];
    logic signed [15:0] weight_mem[W_SIZE];
    logic signed [15:0] bias_mem[cl2d_pkg::MAX_OUT_CH_D];
    logic signed [15:0] sample_mem[X_SIZE];
    bit           weight_set[W_SIZE];
    bit           bias_set[cl2d_pkg::MAX_OUT_CH_D];
    bit           sample_set[X_SIZE];
    int           error_count;
    int           words_sent;
    int           idle_pct;
    int           stall_pct;

    convolution_layer_2d_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .operation(operation), .out_channel(out_channel), .in_channel(in_channel),
        .row_index(row_index), .col_index(col_index), .data_value(data_value),
        .empty(empty), .pop(pop),
        .res_channel(res_channel), .res_row(res_row), .res_col(res_col),
        .res_value(res_value), .res_status(res_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic int clamp_reg(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic layer_geometry(output int pad, output int st, output int h, output int w,
                                  output int nic, output int noc, output int kr,
                                  output int kc, output int yrows, output int ycols);
        pad   = clamp_reg(int'(layer_regs[cl2d_pkg::REG_PAD]), 0, 2);
        st    = clamp_reg(int'(layer_regs[cl2d_pkg::REG_STRIDE]), 1, 4);
        h     = clamp_reg(int'(layer_regs[cl2d_pkg::REG_HEIGHT]), 1, cl2d_pkg::MAX_MAP_DIM_D);
        w     = clamp_reg(int'(layer_regs[cl2d_pkg::REG_WIDTH]), 1, cl2d_pkg::MAX_MAP_DIM_D);
        nic   = clamp_reg(int'(layer_regs[cl2d_pkg::REG_NIC]), 1, cl2d_pkg::MAX_IN_CH_D);
        noc   = clamp_reg(int'(layer_regs[cl2d_pkg::REG_NOC]), 1, cl2d_pkg::MAX_OUT_CH_D);
        kr    = clamp_reg(int'(layer_regs[cl2d_pkg::REG_KR]), 1, cl2d_pkg::MAX_KERNEL_D);
        kc    = clamp_reg(int'(layer_regs[cl2d_pkg::REG_KC]), 1, cl2d_pkg::MAX_KERNEL_D);
        yrows = (h + 2 * pad >= kr) ? (h + 2 * pad - kr) / st + 1 : 0;
        ycols = (w + 2 * pad >= kc) ? (w + 2 * pad - kc) / st + 1 : 0;
    endtask

    function automatic int weight_addr(input int oc, input int ic, input int r, input int c);
        return ((oc * cl2d_pkg::MAX_IN_CH_D + ic) * cl2d_pkg::MAX_KERNEL_D + r)
               * cl2d_pkg::MAX_KERNEL_D + c;
    endfunction

    function automatic int sample_addr(input int ic, input int r, input int c);
        return (ic * cl2d_pkg::MAX_MAP_DIM_D + r) * cl2d_pkg::MAX_MAP_DIM_D + c;
    endfunction

    task automatic predict_conv(input int oc, input int r, input int c,
                                output conv_result_t res);
        int pad, st, h, w, nic, noc, kr, kc, yrows, ycols, pr, pc;
        longint acc;
        layer_geometry(pad, st, h, w, nic, noc, kr, kc, yrows, ycols);
        res.channel = 4'(oc);
        res.row     = 5'(r);
        res.col     = 5'(c);
        res.value   = 0;
        res.status  = 1'b1;
        if (oc < noc && r < yrows && c < ycols)
        begin
            acc = 0;
            for (int k = 0; k < nic; k++)
                for (int i = 0; i < kr; i++)
                    for (int j = 0; j < kc; j++)
                    begin
                        pr = r * st + i - pad;
                        pc = c * st + j - pad;
                        if (pr >= 0 && pr < h && pc >= 0 && pc < w)
                            acc += longint'(weight_mem[weight_addr(oc, k, i, j)]) *
                                   longint'(sample_mem[sample_addr(k, pr, pc)]);
                    end
            acc += longint'(bias_mem[oc]) <<< cl2d_pkg::FRAC_BITS_D;
            acc = acc >>> cl2d_pkg::FRAC_BITS_D;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            res.value  = acc[31:0];
            res.status = 1'b0;
        end
    endtask

    task automatic apply_word(input int op, input int oc, input int ic,
                              input int r, input int c, input int d);
        conv_result_t res;
        case (op)
            cl2d_pkg::OP_WEIGHT:
                if (r < cl2d_pkg::MAX_KERNEL_D && c < cl2d_pkg::MAX_KERNEL_D)
                begin
                    weight_mem[weight_addr(oc, ic, r, c)] = 16'(d);
                    weight_set[weight_addr(oc, ic, r, c)] = 1'b1;
                end
            cl2d_pkg::OP_BIAS:
            begin
                bias_mem[oc] = 16'(d);
                bias_set[oc] = 1'b1;
            end
            cl2d_pkg::OP_SAMPLE:
            begin
                sample_mem[sample_addr(ic, r, c)] = 16'(d);
                sample_set[sample_addr(ic, r, c)] = 1'b1;
            end
            default:
            begin
                predict_conv(oc, r, c, res);
                conv_expected_q.insert(conv_expected_q.size(), res);
            end
        endcase
    endtask

    task automatic send_word(input int op, input int oc, input int ic,
                             input int r, input int c, input int d);
        @(negedge clk);
        push        <= 1'b1;
        operation   <= 2'(op);
        out_channel <= 4'(oc);
        in_channel  <= 4'(ic);
        row_index   <= 5'(r);
        col_index   <= 5'(c);
        data_value  <= 16'(d);
        @(posedge clk);
        while (full) @(posedge clk);
        apply_word(op & 3, oc & 15, ic & 15, r & 31, c & 31, d);
        words_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
    endtask

    // load whatever a compute would read that has not been written yet
    task automatic fill_operands(input int oc, input int r, input int c);
        int pad, st, h, w, nic, noc, kr, kc, yrows, ycols, pr, pc;
        layer_geometry(pad, st, h, w, nic, noc, kr, kc, yrows, ycols);
        if (oc < noc && r < yrows && c < ycols)
        begin
            if (!bias_set[oc])
                send_word(cl2d_pkg::OP_BIAS, oc, $urandom, $urandom, $urandom, $urandom);
            for (int k = 0; k < nic; k++)
                for (int i = 0; i < kr; i++)
                    for (int j = 0; j < kc; j++)
                    begin
                        pr = r * st + i - pad;
                        pc = c * st + j - pad;
                        if (pr >= 0 && pr < h && pc >= 0 && pc < w)
                        begin
                            if (!weight_set[weight_addr(oc, k, i, j)])
                                send_word(cl2d_pkg::OP_WEIGHT, oc, k, i, j, $urandom);
                            if (!sample_set[sample_addr(k, pr, pc)])
                                send_word(cl2d_pkg::OP_SAMPLE, $urandom, k, pr, pc, $urandom);
                        end
                    end
        end
    endtask

    task automatic issue_compute(input int oc, input int r, input int c);
        fill_operands(oc, r, c);
        send_word(cl2d_pkg::OP_COMPUTE, oc, $urandom, r, c, $urandom);
    endtask

    task automatic drain_results();
        @(negedge clk);
        push <= 1'b0;
        wait (conv_expected_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 6'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            cl2d_pkg::REG_PAD:
                layer_regs[idx] = 6'(value) & 6'd3;
            cl2d_pkg::REG_STRIDE, cl2d_pkg::REG_KR, cl2d_pkg::REG_KC:
                layer_regs[idx] = 6'(value) & 6'd7;
            cl2d_pkg::REG_NIC, cl2d_pkg::REG_NOC:
                layer_regs[idx] = 6'(value) & 6'd31;
            default:
                layer_regs[idx] = 6'(value);
        endcase
    endtask

    task automatic set_layer(input int pad, input int st, input int h, input int w,
                             input int nic, input int noc, input int kr, input int kc);
        drain_results();
        write_reg(cl2d_pkg::REG_PAD, pad);
        write_reg(cl2d_pkg::REG_STRIDE, st);
        write_reg(cl2d_pkg::REG_HEIGHT, h);
        write_reg(cl2d_pkg::REG_WIDTH, w);
        write_reg(cl2d_pkg::REG_NIC, nic);
        write_reg(cl2d_pkg::REG_NOC, noc);
        write_reg(cl2d_pkg::REG_KR, kr);
        write_reg(cl2d_pkg::REG_KC, kc);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    always @(negedge clk)
        if (rst_n) pop <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : check_results
        conv_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (conv_expected_q.size() == 0)
            begin
                report_mismatch("result word with nothing expected");
            end
            else
            begin
                want = conv_expected_q.pop_front();
                if (res_channel !== want.channel || res_row !== want.row ||
                    res_col !== want.col || res_value !== want.value ||
                    res_status !== want.status)
                    report_mismatch($sformatf(
                        "got ch %0d r %0d c %0d v %0d st %0b, want %0d %0d %0d %0d %0b",
                        res_channel, res_row, res_col, res_value, res_status,
                        want.channel, want.row, want.col, want.value, want.status));
            end
        end
    end

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        set_layer(1, 2, 4, 4, 1, 2, 3, 3);
        send_word(cl2d_pkg::OP_WEIGHT, 0, 0, 0, 0, 16'sh7fff);
        send_word(cl2d_pkg::OP_WEIGHT, 0, 0, 1, 1, 16'sh8000);
        send_word(cl2d_pkg::OP_WEIGHT, 15, 15, 31, 31, 16'sh1234);
        send_word(cl2d_pkg::OP_WEIGHT, 3, 2, 4, 7, 16'sh0001);
        send_word(cl2d_pkg::OP_BIAS, 0, 0, 0, 0, 16'sh8000);
        send_word(cl2d_pkg::OP_BIAS, 15, 15, 31, 31, 16'sh7fff);
        send_word(cl2d_pkg::OP_SAMPLE, 0, 0, 0, 0, 16'sh8000);
        send_word(cl2d_pkg::OP_SAMPLE, 15, 15, 31, 31, 16'sh7fff);
        send_word(cl2d_pkg::OP_SAMPLE, 0, 0, 3, 3, 16'sh7fff);
        issue_compute(0, 0, 0);
        issue_compute(0, 1, 1);
        issue_compute(1, 0, 1);
        issue_compute(2, 0, 0);
        issue_compute(0, 2, 0);
        issue_compute(15, 31, 31);
    endtask

    task automatic test_extremes();
        set_layer(2, 1, 32, 32, 16, 16, 5, 5);
        issue_compute(0, 0, 0);
        issue_compute(15, 31, 31);
        issue_compute(15, 31, 0);
        set_layer(0, 1, 1, 1, 1, 1, 1, 1);
        issue_compute(0, 0, 0);
        issue_compute(1, 0, 0);
        issue_compute(0, 1, 0);
        set_layer(0, 4, 1, 1, 1, 1, 5, 5);
        issue_compute(0, 0, 0);
        set_layer(3, 0, 0, 63, 0, 31, 7, 0);
        issue_compute(0, 0, 0);
        issue_compute(15, 1, 7);
    endtask

    task automatic random_words(input int count, input bit hold_midway);
        int pad, st, h, w, nic, noc, kr, kc, yrows, ycols, target, oc, r, c, pick;
        layer_geometry(pad, st, h, w, nic, noc, kr, kc, yrows, ycols);
        target = words_sent + count;
        while (words_sent < target)
        begin
            if (hold_midway && words_sent >= target - count / 2)
            begin
                hold_midway = 1'b0;
                @(negedge clk);
                push <= 1'b0;
                wait (conv_expected_q.size() == 0);
            end
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                oc = ($urandom_range(9) != 0) ? $urandom_range(noc - 1) : $urandom_range(15);
                r  = (yrows > 0 && $urandom_range(9) != 0) ? $urandom_range(yrows - 1)
                                                           : $urandom_range(31);
                c  = (ycols > 0 && $urandom_range(9) != 0) ? $urandom_range(ycols - 1)
                                                           : $urandom_range(31);
                issue_compute(oc, r, c);
            end
            else if (pick < 80)
            begin
                send_word(cl2d_pkg::OP_WEIGHT, $urandom_range(noc - 1), $urandom_range(nic - 1),
                          $urandom_range(kr - 1), $urandom_range(kc - 1), $urandom);
            end
            else if (pick < 88)
            begin
                send_word(cl2d_pkg::OP_SAMPLE, $urandom, $urandom_range(nic - 1),
                          $urandom_range(h - 1), $urandom_range(w - 1), $urandom);
            end
            else if (pick < 93)
            begin
                send_word(cl2d_pkg::OP_BIAS, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                send_word($urandom_range(2), $urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_random_stream();
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    idle_pct = 0;  stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 50; stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;  stall_pct = 50;
                end
                default:
                begin
                    idle_pct = 35; stall_pct = 35;
                end
            endcase
            if (ph == 7)
                set_layer($urandom_range(3), $urandom_range(7), $urandom_range(63),
                          $urandom_range(63), $urandom_range(1) ? 0 : 2, $urandom_range(31),
                          $urandom_range(7), $urandom_range(7));
            else
                set_layer($urandom_range(2), $urandom_range(1, 4), $urandom_range(1, 8),
                          $urandom_range(1, 8), $urandom_range(1, 3), $urandom_range(1, 16),
                          $urandom_range(1, 5), $urandom_range(1, 5));
            random_words(95, ph == 3);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = cl2d_pkg::REG_PAD;
        cfg_data    = '0;
        push        = 1'b0;
        operation   = cl2d_pkg::OP_WEIGHT;
        out_channel = '0;
        in_channel  = '0;
        row_index   = '0;
        col_index   = '0;
        data_value  = '0;
        pop         = 1'b0;
        error_count = 0;
        words_sent  = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        layer_regs  = '{6'd0, 6'd1, 6'd28, 6'd28, 6'd1, 6'd6, 6'd5, 6'd5};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_extremes();
        test_random_stream();
        drain_results();
        if (error_count == 0 && conv_expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
